>>> sv/lpps_pkg.sv
`timescale 1ns / 1ps
package lpps_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int FULL_SCALE   = 1020;
  localparam int READING_W    = 10;
  localparam int GAIN_W       = 9;
  localparam int SPEED_W      = 16;
  localparam int POS_W        = 13;
  localparam int SEEN_LIMIT   = 200;
  localparam int WEIGHT_LIMIT = 50;

  localparam int IDX_W       = $clog2(NUM_SENSORS);
  localparam int FS_W        = $clog2(FULL_SCALE + 1);
  localparam int WSUM_MAX    = FULL_SCALE * NUM_SENSORS * (NUM_SENSORS - 1) / 2;
  localparam int WSUM_W      = $clog2(WSUM_MAX + 1);
  localparam int WEIGHTED_W  = $clog2(WSUM_MAX * FULL_SCALE + 1);
  localparam int TOTAL_W     = $clog2(FULL_SCALE * NUM_SENSORS + 1);
  localparam int SCALE_NUM_W = READING_W + FS_W;

  localparam int DIV_NUM_W = (WEIGHTED_W > SCALE_NUM_W) ? WEIGHTED_W : SCALE_NUM_W;
  localparam int DIV_DEN_W = (TOTAL_W > READING_W) ? TOTAL_W : READING_W;

  localparam int FAR_RIGHT = FULL_SCALE * (NUM_SENSORS - 1);
  localparam int MIDDLE    = FAR_RIGHT / 2;
  localparam logic [POS_W-1:0] FAR_RIGHT_POS = POS_W'(FAR_RIGHT);
  localparam logic [POS_W-1:0] MIDDLE_POS    = POS_W'(MIDDLE);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(NUM_SENSORS - 1);

  localparam int MUL_A_W0 = (WSUM_W > READING_W) ? WSUM_W : READING_W;
  localparam int MUL_A_W1 = (MUL_A_W0 > FS_W) ? MUL_A_W0 : FS_W;
  localparam int MUL_A_W  = (MUL_A_W1 > GAIN_W) ? MUL_A_W1 : GAIN_W;
  localparam int MUL_B_W0 = (FS_W + 1 > POS_W + 1) ? FS_W + 1 : POS_W + 1;
  localparam int MUL_B_W  = (MUL_B_W0 > IDX_W + 1) ? MUL_B_W0 : IDX_W + 1;
  localparam int MUL_P_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int CORR_W   = MUL_P_W + 1;
  localparam int OUT_W    = CORR_W + 2;

  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 48;

  localparam logic [READING_W-1:0] BLACK_LEVEL_RST = 10'd720;
  localparam logic [READING_W-1:0] WHITE_LEVEL_RST = 10'd900;
  localparam logic [GAIN_W-1:0]    PROP_GAIN_RST   = 9'd205;
  localparam logic [GAIN_W-1:0]    DERIV_GAIN_RST  = 9'd5;
  localparam logic [READING_W-1:0] BASE_SPEED_RST  = 10'd500;

  typedef enum logic [2:0] {
    REG_BLACK_LEVEL = 3'd0,
    REG_WHITE_LEVEL = 3'd1,
    REG_PROP_GAIN   = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_BASE_SPEED  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_SDIV,
    S_ACC,
    S_WMUL,
    S_CDIV,
    S_ERR,
    S_CORR,
    S_OUT
  } state_t;

endpackage

>>> sv/line_position_pd_steering.sv
`timescale 1ns / 1ps
// Line position and PD steering from one frame of eight ground reflectance
// readings (s_tdata, reading_0 lowest). Each reading is rescaled between
// black_level and white_level to 0..1020, the line position is the weighted
// centroid of the readings, and a Q8 PD step on the position error gives
// the left and right wheel speeds. One frame is in flight at a time:
// s_tready is high only between frames. A frame's length is set by the
// one shared restoring divider that produces one quotient bit per cycle
// and serves each reading that is not clamped, and the centroid, in turn.
// A finished result waits in the output register while the next frame is
// taken; a frame that finishes while that result still waits holds in
// its last step.
module line_position_pd_steering (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // reading_0 .. reading_7, 10 bits each
  input  logic [lpps_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // left_speed[15:0], right_speed[31:16], line_position[44:32],
  // line_seen[45], zero fill[47:46]
  output logic [lpps_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lpps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lpps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lpps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lpps_pkg::*;

  function automatic logic [SPEED_W-1:0] wheel_speed(input logic signed [OUT_W-1:0] x);
    logic signed [OUT_W-1:0] q;
    q = x + $signed(OUT_W'(x[OUT_W-1] ? 255 : 0));
    q = q >>> 8;
    if (q > $signed(OUT_W'(32767))) begin
      return SPEED_W'(32767);
    end else if (q < -$signed(OUT_W'(32768))) begin
      return SPEED_W'(32768);
    end
    return q[SPEED_W-1:0];
  endfunction

  state_t state, state_next;

  logic [READING_W-1:0] black_level, white_level, base_speed;
  logic [GAIN_W-1:0]    prop_gain, deriv_gain;

  logic [READING_W-1:0]     reading [NUM_SENSORS];
  logic [IDX_W-1:0]         idx;
  logic [FS_W-1:0]          s_val;
  logic                     seen;
  logic [WSUM_W-1:0]        wsum;
  logic [TOTAL_W-1:0]       total;
  logic [POS_W-1:0]         held_position;
  logic signed [POS_W-1:0]  previous_error;
  logic signed [CORR_W-1:0] corr;

  logic [SPEED_W-1:0] left_speed, right_speed;
  logic [POS_W-1:0]   line_position;
  logic               line_seen;

  logic [READING_W-1:0]      cur_reading;
  logic signed [READING_W:0] diff, span;
  logic [READING_W-1:0]      mag_a, mag_b;
  logic                      same_side, scale_fixed;
  logic [FS_W-1:0]           scale_fixed_val;
  logic signed [POS_W-1:0]   err;
  logic signed [POS_W:0]     ediff;

  logic [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  logic signed [OUT_W-1:0] base_term, corr_ext;
  logic                    cfg_write;

  lpps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  assign cur_reading     = reading[idx];
  assign diff            = $signed({1'b0, cur_reading}) - $signed({1'b0, black_level});
  assign span            = $signed({1'b0, white_level}) - $signed({1'b0, black_level});
  assign mag_a           = diff[READING_W] ? READING_W'(-diff) : diff[READING_W-1:0];
  assign mag_b           = span[READING_W] ? READING_W'(-span) : span[READING_W-1:0];
  assign same_side       = (diff > 0 && !span[READING_W]) || (diff < 0 && span[READING_W]);
  assign scale_fixed     = !same_side || (mag_a >= mag_b);
  assign scale_fixed_val = same_side ? FS_W'(FULL_SCALE) : '0;

  assign err   = $signed(held_position - MIDDLE_POS);
  assign ediff = $signed({err[POS_W-1], err}) - $signed({previous_error[POS_W-1], previous_error});

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        mul_a = MUL_A_W'(mag_a);
        mul_b = MUL_B_W'(FULL_SCALE);
        if (scale_fixed) begin
          state_next = S_ACC;
        end else begin
          div_start  = 1'b1;
          div_num    = prod[DIV_NUM_W-1:0];
          div_den    = DIV_DEN_W'(mag_b);
          state_next = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        mul_a = MUL_A_W'(s_val);
        mul_b = MUL_B_W'(idx);
        state_next = (idx == LAST_IDX) ? S_WMUL : S_SCALE;
      end
      S_WMUL: begin
        mul_a = MUL_A_W'(wsum);
        mul_b = MUL_B_W'(FULL_SCALE);
        if (seen && total != '0) begin
          div_start  = 1'b1;
          div_num    = prod[DIV_NUM_W-1:0];
          div_den    = DIV_DEN_W'(total);
          state_next = S_CDIV;
        end else begin
          state_next = S_ERR;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        mul_a = MUL_A_W'(prop_gain);
        mul_b = MUL_B_W'(err);
        state_next = S_CORR;
      end
      S_CORR: begin
        mul_a = MUL_A_W'(deriv_gain);
        mul_b = MUL_B_W'(ediff);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // frame datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          for (int i = 0; i < NUM_SENSORS; i++) begin
            reading[i] <= s_tdata[i*READING_W +: READING_W];
          end
          idx   <= '0;
          seen  <= 1'b0;
          wsum  <= '0;
          total <= '0;
        end
      end
      S_SCALE: begin
        if (scale_fixed) begin
          s_val <= scale_fixed_val;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          s_val <= div_quo[FS_W-1:0];
        end
      end
      S_ACC: begin
        if (s_val < FS_W'(SEEN_LIMIT)) begin
          seen <= 1'b1;
        end
        if (s_val > FS_W'(WEIGHT_LIMIT)) begin
          wsum  <= wsum + prod[WSUM_W-1:0];
          total <= total + TOTAL_W'(s_val);
        end
        idx <= idx + 1'b1;
      end
      S_ERR: begin
        corr <= CORR_W'(prod);
      end
      S_CORR: begin
        corr <= corr + CORR_W'(prod);
      end
      default: begin
      end
    endcase
  end

  // state carried across frames
  always_ff @(posedge clk) begin
    if (rst) begin
      held_position  <= '0;
      previous_error <= '0;
    end else begin
      if (state == S_WMUL && !seen) begin
        if (32'(held_position) < 32'(MIDDLE)) begin
          held_position <= '0;
        end else begin
          held_position <= FAR_RIGHT_POS;
        end
      end else if (state == S_CDIV && div_done) begin
        held_position <= div_quo[POS_W-1:0];
      end
      if (state == S_CORR) begin
        previous_error <= err;
      end
    end
  end

  assign base_term = $signed(OUT_W'({base_speed, 8'b0}));
  assign corr_ext  = OUT_W'(corr);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      left_speed    <= wheel_speed(base_term - corr_ext);
      right_speed   <= wheel_speed(base_term + corr_ext);
      line_position <= held_position;
      line_seen     <= seen;
    end
  end

  assign m_tdata = {2'b00, line_seen, line_position, right_speed, left_speed};

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_level <= BLACK_LEVEL_RST;
      white_level <= WHITE_LEVEL_RST;
      prop_gain   <= PROP_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      base_speed  <= BASE_SPEED_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
        REG_BLACK_LEVEL: black_level <= pwdata[READING_W-1:0];
        REG_WHITE_LEVEL: white_level <= pwdata[READING_W-1:0];
        REG_PROP_GAIN:   prop_gain   <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= pwdata[GAIN_W-1:0];
        REG_BASE_SPEED:  base_speed  <= pwdata[READING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
      REG_BLACK_LEVEL: prdata = APB_DATA_W'(black_level);
      REG_WHITE_LEVEL: prdata = APB_DATA_W'(white_level);
      REG_PROP_GAIN:   prdata = APB_DATA_W'(prop_gain);
      REG_DERIV_GAIN:  prdata = APB_DATA_W'(deriv_gain);
      REG_BASE_SPEED:  prdata = APB_DATA_W'(base_speed);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> sv/lpps_div.sv
`timescale 1ns / 1ps
module lpps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lpps_pkg::DIV_NUM_W-1:0] num,
  input  logic [lpps_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [lpps_pkg::DIV_NUM_W-1:0] quo
);
  import lpps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= rem_sub[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/lpps_checker.sv
`timescale 1ns / 1ps
module lpps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lpps_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lpps_pkg::*;

  // one frame at a time: drop ready right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("s_tready stayed high after an input request");

  // a new result only appears after a frame was in work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a frame in work");

  // lost line snaps to an edge
  a_lost_line_snaps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[45] |->
      (m_tdata[44:32] == '0 || m_tdata[44:32] == FAR_RIGHT_POS))
    else $error("lost line position not snapped to an edge");

  // hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind line_position_pd_steering lpps_checker u_lpps_checker (.*);
